// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the text parser.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/uitp_pkg.sv =====
// Types, constants and helper functions of the unsigned integer text parser.
// Depends on nothing; imported by unsigned_integer_text_parser.
package uitp_pkg;

    localparam int VALUE_BITS = 64;
    localparam int COUNT_BITS = 8;
    localparam int BASE_BITS  = 6;
    localparam int DIGIT_BITS = 7;
    localparam int PROD_BITS  = VALUE_BITS + BASE_BITS + 1;
    localparam int CHAR_BITS  = 8;
    localparam int OUT_COUNT_BITS = 8;
    localparam int ADDR_BITS  = 3;

    localparam logic [DIGIT_BITS-1:0] NO_DIGIT = DIGIT_BITS'(64);
    localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
    localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
    localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
    localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);

    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UP_OFS = 8'h41 - 8'd10;
    localparam logic [CHAR_BITS-1:0] CH_LO_OFS = 8'h61 - 8'd10;
    localparam logic [CHAR_BITS-1:0] CH_LO_X   = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;

    // Register index of the base register
    localparam logic REG_NUMBER_BASE = 1'b0;

    typedef enum logic [2:0] {
        PH_START,
        PH_AFTER_SIGN,
        PH_PENDING_ZERO,
        PH_AFTER_PREFIX,
        PH_DIGITS
    } t_phase;

    // Map a character to its digit value, NO_DIGIT for anything else
    function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
        logic [DIGIT_BITS-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_BITS'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = DIGIT_BITS'(c - CH_UP_OFS);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = DIGIT_BITS'(c - CH_LO_OFS);
        end
        return d;
    endfunction

    // Increment a character count, holding at its maximum
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    // Clamp the internal count to the reported width
    function automatic logic [OUT_COUNT_BITS-1:0] report_count(
        input logic [COUNT_BITS-1:0] c);
        logic [15:0] w;
        w = 16'(c);
        return (w > 16'(255)) ? OUT_COUNT_BITS'(255) : w[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

// ===== hdl/unsigned_integer_text_parser.sv =====
// Streaming unsigned integer text parser: one character per request.
// Depends on uitp_pkg and assert_macros.svh.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_text_char
//   result    out        o_out_valid / i_out_stall o_parsed_value, o_chars_consumed,
//                                                  o_overflowed
//   config    in (APB)   psel/penable/pready       paddr, pwdata, prdata
//
// One character per cycle unless the input stalls; a result appears in the
// output register in the cycle after the character that ends the number is
// accepted. The path is set by the 64 x 6 bit multiply-add of the accumulator.
// Reset clears the parse state and the output valid. A stalled result holds the
// output register and stalls the input only while that register is full.
`include "assert_macros.svh"

module unsigned_integer_text_parser
    import uitp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // character input
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [CHAR_BITS-1:0]      i_text_char,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [63:0]               o_parsed_value,
    output logic [OUT_COUNT_BITS-1:0] o_chars_consumed,
    output logic                      o_overflowed,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_BITS-1:0]      paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // configuration register
    logic [BASE_BITS-1:0] r_number_base;

    // parse state
    t_phase                r_phase,    n_phase;
    logic [VALUE_BITS-1:0] r_acc,      n_acc;
    logic                  r_minus,    n_minus;
    logic                  r_dseen,    n_dseen;
    logic                  r_ovf,      n_ovf;
    logic [BASE_BITS-1:0]  r_base,     n_base;
    logic [COUNT_BITS-1:0] r_count,    n_count;

    // output register
    logic                      r_out_valid;
    logic [VALUE_BITS-1:0]     r_out_value,  n_out_value;
    logic [OUT_COUNT_BITS-1:0] r_out_count,  n_out_count;
    logic                      r_out_ovf,    n_out_ovf;
    logic                      n_emit;

    logic in_accept;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_NUMBER_BASE) ? 32'(r_number_base) : 32'd0;

    // stall input only while a result is waiting and the sink stalls
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // write the base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_AUTO;
        end else if (cfg_write && paddr[2] == REG_NUMBER_BASE) begin
            r_number_base <= pwdata[BASE_BITS-1:0];
        end
    end

    // advance the parse by one character
    always_comb begin
        logic [BASE_BITS-1:0]  v_eff;
        logic                  v_first;
        logic                  v_digit;
        logic [DIGIT_BITS-1:0] v_d;
        logic [PROD_BITS-1:0]  v_sum;
        logic [VALUE_BITS-1:0] v_val;

        n_phase = r_phase;
        n_acc   = r_acc;
        n_minus = r_minus;
        n_dseen = r_dseen;
        n_ovf   = r_ovf;
        n_base  = r_base;
        n_count = r_count;
        n_emit  = 1'b0;
        n_out_value = r_out_value;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        v_first = 1'b0;
        v_digit = 1'b0;
        v_d     = digit_value(i_text_char);
        v_eff   = BASE_DEC;
        v_sum   = '0;
        v_val   = '0;

        case (r_phase)
            PH_START: begin
                n_base = r_number_base;
                if (i_text_char == CH_MINUS || i_text_char == CH_PLUS) begin
                    n_minus = (i_text_char == CH_MINUS);
                    n_count = sat_inc(r_count);
                    n_phase = PH_AFTER_SIGN;
                end else begin
                    v_first = 1'b1;
                end
            end
            PH_AFTER_SIGN: begin
                v_first = 1'b1;
            end
            PH_PENDING_ZERO: begin
                if (i_text_char == CH_LO_X || i_text_char == CH_UP_X) begin
                    n_base  = BASE_HEX;
                    n_count = sat_inc(r_count);
                    n_phase = PH_AFTER_PREFIX;
                end else begin
                    if (r_base == BASE_AUTO) begin
                        n_base = BASE_OCT;
                    end
                    n_acc   = '0;
                    n_dseen = 1'b1;
                    v_digit = 1'b1;
                end
            end
            PH_AFTER_PREFIX, PH_DIGITS: begin
                v_digit = 1'b1;
            end
            default: begin
                n_phase = PH_START;
                n_acc   = '0;
                n_minus = 1'b0;
                n_dseen = 1'b0;
                n_ovf   = 1'b0;
                n_base  = BASE_AUTO;
                n_count = '0;
            end
        endcase

        // first character after an optional sign: hold a leading zero in auto or hex base
        if (v_first) begin
            if ((n_base == BASE_AUTO || n_base == BASE_HEX) && i_text_char == CH_ZERO) begin
                n_count = sat_inc(n_count);
                n_phase = PH_PENDING_ZERO;
            end else begin
                if (n_base == BASE_AUTO) begin
                    n_base = BASE_DEC;
                end
                v_digit = 1'b1;
            end
        end

        // take a digit or end the number
        if (v_digit) begin
            v_eff = (n_base == BASE_AUTO) ? BASE_DEC : n_base;
            if (v_d >= DIGIT_BITS'(v_eff)) begin
                v_val = n_acc;
                if (n_ovf) begin
                    v_val = '1;
                end else if (n_minus) begin
                    v_val = '0 - n_acc;
                end
                if (!n_dseen) begin
                    v_val = '0;
                end
                n_emit      = 1'b1;
                n_out_value = v_val;
                n_out_count = n_dseen ? report_count(n_count) : '0;
                n_out_ovf   = n_ovf;
                n_phase = PH_START;
                n_acc   = '0;
                n_minus = 1'b0;
                n_dseen = 1'b0;
                n_ovf   = 1'b0;
                n_base  = BASE_AUTO;
                n_count = '0;
            end else begin
                v_sum = PROD_BITS'(n_acc) * PROD_BITS'(v_eff) + PROD_BITS'(v_d);
                if (n_ovf || (|v_sum[PROD_BITS-1:VALUE_BITS])) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = v_sum[VALUE_BITS-1:0];
                end
                n_dseen = 1'b1;
                n_count = sat_inc(n_count);
                n_phase = PH_DIGITS;
            end
        end
    end

    // hold parse state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_acc       <= '0;
            r_minus     <= 1'b0;
            r_dseen     <= 1'b0;
            r_ovf       <= 1'b0;
            r_base      <= BASE_AUTO;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_minus <= n_minus;
                r_dseen <= n_dseen;
                r_ovf   <= n_ovf;
                r_base  <= n_base;
                r_count <= n_count;
            end
            if (in_accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_out_value <= n_out_value;
            r_out_count <= n_out_count;
            r_out_ovf   <= n_out_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_parsed_value   = 64'(r_out_value);
    assign o_chars_consumed = r_out_count;
    assign o_overflowed     = r_out_ovf;

    // a finished number leaves a clean parse state
    `ASSERT_NEXT(a_clear_after_result, i_clk, i_rst_n, in_accept && n_emit,
        r_phase == PH_START && r_count == '0 && !r_dseen && !r_ovf)
    // no digit means a zero result without overflow
    `ASSERT_IMPLY(a_no_digit_zero, i_clk, i_rst_n, o_out_valid && o_chars_consumed == '0,
        o_parsed_value == '0 && !o_overflowed)
    // overflow reports all ones
    `ASSERT_IMPLY(a_ovf_all_ones, i_clk, i_rst_n, o_out_valid && o_overflowed,
        &o_parsed_value)
    // a pending zero only in auto or hex base and already counted
    `ASSERT_IMPLY(a_pending_zero, i_clk, i_rst_n, r_phase == PH_PENDING_ZERO,
        (r_base == BASE_AUTO || r_base == BASE_HEX) && r_count != '0)

endmodule
